// ===== design/lbp_pkg.sv =====
// ----------------------------------------------------------------------------
// LED blink pattern player package
// Shared widths, command codes and word types for the pattern player.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lbp_pkg;

    // Field widths of the command and result words.
    localparam int KIND_W        = 3;
    localparam int COUNT_W       = 16;
    localparam int ENTRY_INDEX_W = 3;
    localparam int DELAY_W       = 16;

    // Number of store positions that an entry index can address.
    localparam int ENTRY_SPAN = 2 ** ENTRY_INDEX_W;

    // Default depth of the pattern store.
    localparam int DEFAULT_PATTERN_DEPTH = 8;

    // Command codes carried in the kind field.
    typedef enum logic [KIND_W-1:0] {
        KIND_TICK    = 3'd0,
        KIND_PLAY    = 3'd1,
        KIND_RESTART = 3'd2,
        KIND_WRITE   = 3'd3,
        KIND_CLEAR   = 3'd4
    } kind_t;

    // One command word.
    typedef struct packed {
        logic [KIND_W-1:0]        kind;
        logic signed [COUNT_W-1:0] count;
        logic [ENTRY_INDEX_W-1:0] entry_index;
        logic [DELAY_W-1:0]       delay_ms;
    } cmd_t;

    // One result word.
    typedef struct packed {
        logic led_on;
        logic active;
    } rsp_t;

endpackage

// ===== design/lbp_cmd_if.sv =====
// ----------------------------------------------------------------------------
// Command channel
// Valid/ready channel that carries one command word to the pattern player.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface lbp_cmd_if;

    logic                                 valid;
    logic                                 ready;
    logic [lbp_pkg::KIND_W-1:0]           kind;
    logic signed [lbp_pkg::COUNT_W-1:0]   count;
    logic [lbp_pkg::ENTRY_INDEX_W-1:0]    entry_index;
    logic [lbp_pkg::DELAY_W-1:0]          delay_ms;

    modport source (output valid, output kind, output count, output entry_index,
                    output delay_ms, input ready);
    modport sink   (input valid, input kind, input count, input entry_index,
                    input delay_ms, output ready);

endinterface

// ===== design/lbp_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel that carries one result word from the pattern player.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface lbp_rsp_if;

    logic valid;
    logic ready;
    logic led_on;
    logic active;

    modport source (output valid, output led_on, output active, input ready);
    modport sink   (input valid, input led_on, input active, output ready);

endinterface

// ===== design/lbp_core.sv =====
// ----------------------------------------------------------------------------
// Pattern player core
// Holds the pattern store and the playback state, and applies one command
// word per step. The result word reflects the state after that command.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lbp_core #(
    parameter int PATTERN_DEPTH = lbp_pkg::DEFAULT_PATTERN_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          step,
    input  lbp_pkg::cmd_t cmd,
    output lbp_pkg::rsp_t rsp
);

    import lbp_pkg::*;

    // Only the positions that an entry index reaches can ever be written.
    localparam int STORE_DEPTH = (PATTERN_DEPTH < ENTRY_SPAN) ? PATTERN_DEPTH : ENTRY_SPAN;
    localparam int IDX_W       = $clog2(STORE_DEPTH);
    localparam int POS_W       = $clog2(PATTERN_DEPTH + 1);

    logic [DELAY_W-1:0]        pattern_store_reg [STORE_DEPTH];
    logic                      present_reg, present_next;
    logic [POS_W-1:0]          position_reg, position_next;
    logic signed [COUNT_W-1:0] passes_reg, passes_next;
    logic [DELAY_W-1:0]        wait_reg, wait_next;
    logic                      light_reg, light_next;
    logic                      store_we;
    logic                      index_ok;

    assign index_ok = (32'(cmd.entry_index) < 32'(PATTERN_DEPTH));

    // Command decode followed by the playback update.
    always_comb
    begin
        logic signed [COUNT_W-1:0] p;
        logic [DELAY_W-1:0]        w;
        logic [DELAY_W-1:0]        r;
        logic [POS_W-1:0]          pos;
        logic                      lt;
        logic                      fire;

        p            = passes_reg;
        w            = wait_reg;
        pos          = position_reg;
        lt           = light_reg;
        r            = '0;
        fire         = 1'b0;
        store_we     = 1'b0;
        present_next = present_reg;

        if (step)
        begin
            case (kind_t'(cmd.kind))
                KIND_TICK:
                begin
                    if (w != '0)
                    begin
                        w = w - DELAY_W'(1);
                    end
                    fire = 1'b1;
                end
                KIND_PLAY:
                begin
                    if (present_reg)
                    begin
                        if (p == '0)
                        begin
                            w = '0;
                        end
                        p    = cmd.count;
                        fire = 1'b1;
                    end
                end
                KIND_RESTART:
                begin
                    pos  = '0;
                    w    = '0;
                    lt   = 1'b0;
                    p    = present_reg ? cmd.count : '0;
                    fire = 1'b1;
                end
                KIND_WRITE:
                begin
                    if (index_ok)
                    begin
                        store_we     = 1'b1;
                        present_next = 1'b1;
                    end
                end
                KIND_CLEAR:
                begin
                    present_next = 1'b0;
                    p            = '0;
                    pos          = '0;
                    w            = '0;
                    lt           = 1'b0;
                end
                default:
                begin
                end
            endcase
        end

        // While passes remain and the wait has run out, fetch the next delay and toggle the LED.
        // A zero entry ends the pass: the position wraps and, with passes left, the LED restarts on.
        if (fire)
        begin
            if (p != '0)
            begin
                if (w == '0)
                begin
                    r   = (pos < POS_W'(STORE_DEPTH)) ? pattern_store_reg[pos[IDX_W-1:0]] : '0;
                    pos = pos + POS_W'(1);
                    if (r == '0)
                    begin
                        lt  = 1'b0;
                        pos = '0;
                        if (p > 0)
                        begin
                            p = p - COUNT_W'(1);
                        end
                        if (p != '0)
                        begin
                            r   = pattern_store_reg[0];
                            pos = POS_W'(1);
                            if (r == '0)
                            begin
                                pos = '0;
                                p   = '0;
                            end
                        end
                    end
                    lt = (r != '0) ? !lt : 1'b0;
                    w  = r;
                end
            end
            else
            begin
                lt = 1'b0;
            end
        end

        passes_next   = p;
        wait_next     = w;
        position_next = pos;
        light_next    = lt;
    end

    // Playback state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            present_reg  <= 1'b0;
            position_reg <= '0;
            passes_reg   <= '0;
            wait_reg     <= '0;
            light_reg    <= 1'b0;
        end
        else
        begin
            present_reg  <= present_next;
            position_reg <= position_next;
            passes_reg   <= passes_next;
            wait_reg     <= wait_next;
            light_reg    <= light_next;
        end
    end

    // Pattern store; its contents are meaningless until written.
    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            pattern_store_reg[cmd.entry_index[IDX_W-1:0]] <= cmd.delay_ms;
        end
    end

    assign rsp.led_on = light_next;
    assign rsp.active = (passes_next != '0);

endmodule

// ===== design/led_blink_pattern_player.sv =====
// ----------------------------------------------------------------------------
// LED blink pattern player
// Plays a stored pattern of tick delays on one LED. Every command word
// (tick, play, restart, entry write, pattern clear) yields exactly one result
// word giving the LED level and whether a play count is still running. The
// block takes one command word per clock cycle for as long as results are
// taken; a result passes through the command register and then the result
// register after its command is accepted. The whole update of a command,
// including the pattern store read at the current position, is done
// combinationally between those two registers, and the result register
// lets a new command in while a finished result still waits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module led_blink_pattern_player #(
    parameter int PATTERN_DEPTH = lbp_pkg::DEFAULT_PATTERN_DEPTH
) (
    input  logic         clk,
    input  logic         rst_n,
    lbp_cmd_if.sink      cmd,
    lbp_rsp_if.source    rsp
);

    import lbp_pkg::*;

    cmd_t cmd_reg;
    logic in_valid_reg;
    rsp_t rsp_reg;
    rsp_t core_rsp;
    logic out_valid_reg;
    logic advance;
    logic step;

    // The result register moves on when empty or when its word is taken.
    assign advance   = !out_valid_reg || rsp.ready;
    assign cmd.ready = !in_valid_reg || advance;
    assign step      = in_valid_reg && advance;

    // Handshake state of both stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.valid && cmd.ready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= step;
            end
        end
    end

    // Command and result words.
    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            cmd_reg.kind        <= cmd.kind;
            cmd_reg.count       <= cmd.count;
            cmd_reg.entry_index <= cmd.entry_index;
            cmd_reg.delay_ms    <= cmd.delay_ms;
        end
        if (step)
        begin
            rsp_reg <= core_rsp;
        end
    end

    lbp_core #(
        .PATTERN_DEPTH(PATTERN_DEPTH)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .cmd   (cmd_reg),
        .rsp   (core_rsp)
    );

    assign rsp.valid  = out_valid_reg;
    assign rsp.led_on = rsp_reg.led_on;
    assign rsp.active = rsp_reg.active;

endmodule

// ===== design/lbp_checker.sv =====
// ----------------------------------------------------------------------------
// Pattern player port checker
// Watches the ports of the pattern player and flags broken behaviour.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lbp_checker (
    input logic clk,
    input logic rst_n,
    input logic cmd_valid,
    input logic cmd_ready,
    input logic rsp_valid,
    input logic rsp_ready,
    input logic rsp_led_on,
    input logic rsp_active
);

    // A stalled result word holds its value.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_led_on) && $stable(rsp_active))
        else $error("result word changed while stalled");

    // The LED can only be lit while a play count is running.
    a_led_needs_active: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !rsp_led_on || rsp_active)
        else $error("LED lit with no play count running");

    // A sink that takes results never holds back the command side.
    a_no_bubble: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_ready |-> cmd_ready)
        else $error("command stalled while results are being taken");

    // An accepted word reaches the result side if the result register can move after it is accepted.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready ##1 rsp_ready |=> rsp_valid)
        else $error("accepted word did not produce a result");

endmodule

bind led_blink_pattern_player lbp_checker u_lbp_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (cmd.valid),
    .cmd_ready  (cmd.ready),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .rsp_led_on (rsp.led_on),
    .rsp_active (rsp.active)
);
